// ----- rtl/lrf_pkg.sv -----
// ----------------------------------------------------------------------------
// lrf_pkg
// Types and constants shared by the limited reference filter modules.
// ----------------------------------------------------------------------------
package lrf_pkg;

    typedef struct packed {
        logic signed [31:0] cmd_x;
        logic signed [31:0] cmd_y;
        logic signed [31:0] cmd_z;
        logic signed [31:0] cmd_heading;
        logic               restart;
        logic signed [31:0] meas_x;
        logic signed [31:0] meas_y;
        logic signed [31:0] meas_z;
        logic signed [31:0] meas_heading;
    } tick_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [31:0] acc_x;
        logic signed [31:0] acc_y;
        logic signed [31:0] acc_z;
        logic signed [31:0] heading;
        logic signed [31:0] heading_rate;
        logic signed [31:0] heading_accel;
    } result_t;

    // filter gains, both unsigned q16.16 saturated to 31 bits
    typedef struct packed {
        logic [30:0] k1;
        logic [30:0] k2;
    } gain_t;

    typedef struct packed {
        logic [30:0] jerk;
        logic [30:0] acc;
        logic [30:0] vel;
    } limits_t;

    typedef enum logic [2:0] {
        REG_NATURAL_FREQ   = 3'd0,
        REG_DAMPING_RATIO  = 3'd1,
        REG_LIN_JERK_LIMIT = 3'd2,
        REG_LIN_ACC_LIMIT  = 3'd3,
        REG_LIN_VEL_LIMIT  = 3'd4,
        REG_YAW_JERK_LIMIT = 3'd5,
        REG_YAW_ACC_LIMIT  = 3'd6,
        REG_YAW_VEL_LIMIT  = 3'd7
    } reg_idx_t;

    localparam logic [30:0] NATURAL_FREQ_RST = 31'd65536;
    localparam logic [30:0] DAMPING_RATIO_RST = 31'd32768;
    localparam logic [30:0] JERK_LIMIT_RST = 31'd22938;
    localparam logic [30:0] ACC_LIMIT_RST = 31'd49152;
    localparam logic [30:0] VEL_LIMIT_RST = 31'd98304;

    // pi and two pi in q16.16
    localparam logic signed [33:0] PI_Q = 34'sd205887;
    localparam logic signed [33:0] TWO_PI_Q = 34'sd411775;

    typedef enum logic [1:0] {
        GAIN_IDLE,
        GAIN_SQUARE,
        GAIN_DAMP
    } gain_state_t;

    typedef enum logic [3:0] {
        LANE_IDLE,
        LANE_ERR,
        LANE_MUL_K1,
        LANE_MUL_K2,
        LANE_DEMAND,
        LANE_DIV_LO,
        LANE_DIV_HI,
        LANE_DIV_Q,
        LANE_DIV_FIX,
        LANE_APPLY
    } lane_state_t;

    // which quotient the lane divider is producing
    typedef enum logic [1:0] {
        DIV_JERK,
        DIV_ACC,
        DIV_VEL
    } div_sel_t;

    typedef enum logic [1:0] {
        TOP_IDLE,
        TOP_GAIN,
        TOP_RUN,
        TOP_DONE
    } top_state_t;

endpackage

// ----- rtl/lrf_gain.sv -----
// ----------------------------------------------------------------------------
// lrf_gain
// Computes k1 = omega^2 and k2 = 2*zeta*omega with one shared multiplier.
// ----------------------------------------------------------------------------
module lrf_gain (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [30:0]    natural_freq,
    input  logic [30:0]    damping_ratio,
    output logic           done,
    output lrf_pkg::gain_t gain
);

    localparam logic [45:0] K_MAX = 46'h7FFF_FFFF;

    lrf_pkg::gain_state_t state_reg, state_next;
    logic [61:0] prod_reg, prod_next;
    logic [30:0] k1_reg, k1_next;
    logic [30:0] k2_reg, k2_next;
    logic [30:0] mul_b;
    logic [45:0] scaled;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lrf_pkg::GAIN_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        k1_reg   <= k1_next;
        k2_reg   <= k2_next;
    end

    always_comb
    begin
        state_next = state_reg;
        prod_next  = prod_reg;
        k1_next    = k1_reg;
        k2_next    = k2_reg;
        done       = 1'b0;
        mul_b      = natural_freq;
        scaled     = prod_reg[61:16];
        unique case (state_reg)
            lrf_pkg::GAIN_IDLE:
            begin
                if (start)
                begin
                    prod_next  = natural_freq * mul_b;
                    state_next = lrf_pkg::GAIN_SQUARE;
                end
            end
            lrf_pkg::GAIN_SQUARE:
            begin
                k1_next    = (scaled > K_MAX) ? K_MAX[30:0] : scaled[30:0];
                mul_b      = damping_ratio;
                prod_next  = natural_freq * mul_b;
                state_next = lrf_pkg::GAIN_DAMP;
            end
            lrf_pkg::GAIN_DAMP:
            begin
                // the factor two folds into a shift of 15
                scaled     = prod_reg[60:15];
                if (prod_reg[61])
                begin
                    k2_next = K_MAX[30:0];
                end
                else
                begin
                    k2_next = (scaled > K_MAX) ? K_MAX[30:0] : scaled[30:0];
                end
                done       = 1'b1;
                state_next = lrf_pkg::GAIN_IDLE;
            end
            default:
            begin
                state_next = lrf_pkg::GAIN_IDLE;
            end
        endcase
    end

    assign gain.k1 = k1_reg;
    assign gain.k2 = k2_reg;

    a_done_after_damp: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> state_reg == lrf_pkg::GAIN_DAMP)
        else $error("gain done outside final step");

    a_start_leads_square: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lrf_pkg::GAIN_IDLE && start |=> state_reg == lrf_pkg::GAIN_SQUARE)
        else $error("gain start not taken");

    a_square_then_damp: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lrf_pkg::GAIN_SQUARE |=> state_reg == lrf_pkg::GAIN_DAMP)
        else $error("gain sequence broken");

endmodule

// ----- rtl/lrf_lane.sv -----
// ----------------------------------------------------------------------------
// lrf_lane
// One axis of the filter: error, demand, jerk/acc/vel limits and integration,
// sequenced over one multiplier and a reciprocal divide-by-tick unit.
// ----------------------------------------------------------------------------
module lrf_lane #(
    parameter int TICK_HZ   = 100,
    parameter int WORD_BITS = 32,
    parameter bit ANGLE     = 1'b0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               restart,
    input  logic signed [31:0] cmd,
    input  logic signed [31:0] meas,
    input  lrf_pkg::gain_t     gain,
    input  lrf_pkg::limits_t   lim,
    output logic               busy,
    output logic signed [31:0] pos,
    output logic signed [31:0] vel,
    output logic signed [31:0] acc
);

    localparam int SAT_BITS = (WORD_BITS < 32) ? WORD_BITS : 32;
    localparam int DW = 52;
    localparam logic signed [DW-1:0] SAT_HI = DW'((64'sd1 <<< (SAT_BITS - 1)) - 64'sd1);
    localparam logic signed [DW-1:0] SAT_LO = -SAT_HI - DW'(1);
    localparam logic signed [DW-1:0] S32_HI = DW'(64'sd2147483647);
    localparam logic signed [DW-1:0] S32_LO = -S32_HI - DW'(1);
    // floor(2^48 / tick rate), applied in two halves
    localparam logic [47:0] RECIP = 48'((64'd1 << 48) / TICK_HZ);
    localparam logic [23:0] RECIP_LO = RECIP[23:0];
    localparam logic [23:0] RECIP_HI = RECIP[47:24];
    localparam logic [14:0] TICK_C = 15'(TICK_HZ);

    function automatic logic signed [31:0] sat_word(input logic signed [DW-1:0] v);
        logic signed [31:0] r;
        if (v > SAT_HI)
        begin
            r = SAT_HI[31:0];
        end
        else if (v < SAT_LO)
        begin
            r = SAT_LO[31:0];
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [DW-1:0] v);
        logic signed [31:0] r;
        if (v > S32_HI)
        begin
            r = S32_HI[31:0];
        end
        else if (v < S32_LO)
        begin
            r = S32_LO[31:0];
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [DW-1:0] clamp(input logic signed [DW-1:0] v,
                                                   input logic [30:0] m);
        logic signed [DW-1:0] ms;
        logic signed [DW-1:0] r;
        ms = $signed({{(DW - 31){1'b0}}, m});
        if (v > ms)
        begin
            r = ms;
        end
        else if (v < -ms)
        begin
            r = -ms;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    lrf_pkg::lane_state_t state_reg, state_next;
    lrf_pkg::div_sel_t    sel_reg, sel_next;

    logic signed [31:0] p_reg, p_next;
    logic signed [31:0] v_reg, v_next;
    logic signed [31:0] a_reg, a_next;
    logic signed [31:0] err_reg, err_next;
    logic signed [65:0] prod_reg, prod_next;
    logic signed [65:0] lo_reg, lo_next;
    logic signed [DW-1:0] t1_reg, t1_next;
    logic signed [DW-1:0] d_reg, d_next;
    logic signed [31:0] x_reg, x_next;
    logic signed [32:0] q0_reg, q0_next;
    logic signed [32:0] q_reg, q_next;
    logic signed [31:0] na_reg, na_next;
    logic signed [31:0] nv_reg, nv_next;

    logic signed [32:0] mul_a, mul_b;
    logic signed [33:0] e_raw;
    logic signed [79:0] qsum;
    logic signed [48:0] rem;
    logic signed [DW-1:0] jq, diff, na_w, nv_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lrf_pkg::LANE_IDLE;
            sel_reg   <= lrf_pkg::DIV_JERK;
            p_reg     <= '0;
            v_reg     <= '0;
            a_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            p_reg     <= p_next;
            v_reg     <= v_next;
            a_reg     <= a_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg  <= err_next;
        prod_reg <= prod_next;
        lo_reg   <= lo_next;
        t1_reg   <= t1_next;
        d_reg    <= d_next;
        x_reg    <= x_next;
        q0_reg   <= q0_next;
        q_reg    <= q_next;
        na_reg   <= na_next;
        nv_reg   <= nv_next;
    end

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        p_next     = p_reg;
        v_next     = v_reg;
        a_next     = a_reg;
        err_next   = err_reg;
        lo_next    = lo_reg;
        t1_next    = t1_reg;
        d_next     = d_reg;
        x_next     = x_reg;
        q0_next    = q0_reg;
        q_next     = q_reg;
        na_next    = na_reg;
        nv_next    = nv_reg;
        mul_a      = 33'(x_reg);
        mul_b      = $signed({9'b0, RECIP_LO});
        prod_next  = prod_reg;

        // error, wrapped into plus or minus pi on the heading lane
        e_raw = 34'(cmd) - 34'(p_reg);
        if (ANGLE)
        begin
            if (e_raw > lrf_pkg::PI_Q)
            begin
                e_raw = e_raw - lrf_pkg::TWO_PI_Q;
            end
            else if (e_raw < -lrf_pkg::PI_Q)
            begin
                e_raw = e_raw + lrf_pkg::TWO_PI_Q;
            end
        end

        qsum = (80'(prod_reg) <<< 24) + 80'(lo_reg);
        rem  = 49'(x_reg) - 49'(q0_reg * $signed({1'b0, TICK_C}));

        jq   = DW'(q_reg);
        diff = d_reg - DW'(a_reg);
        na_w = d_reg;
        if (diff > jq)
        begin
            na_w = DW'(a_reg) + jq;
        end
        else if (diff < -jq)
        begin
            na_w = DW'(a_reg) - jq;
        end
        na_w = clamp(na_w, lim.acc);
        nv_w = clamp(DW'(v_reg) + DW'(q_reg), lim.vel);

        unique case (state_reg)
            lrf_pkg::LANE_IDLE:
            begin
                if (start)
                begin
                    if (restart)
                    begin
                        p_next = sat_word(DW'(meas));
                        v_next = '0;
                        a_next = '0;
                    end
                    else
                    begin
                        state_next = lrf_pkg::LANE_ERR;
                    end
                end
            end
            lrf_pkg::LANE_ERR:
            begin
                err_next   = sat32(DW'(e_raw));
                state_next = lrf_pkg::LANE_MUL_K1;
            end
            lrf_pkg::LANE_MUL_K1:
            begin
                mul_a      = $signed({2'b0, gain.k1});
                mul_b      = 33'(err_reg);
                prod_next  = mul_a * mul_b;
                state_next = lrf_pkg::LANE_MUL_K2;
            end
            lrf_pkg::LANE_MUL_K2:
            begin
                t1_next    = DW'(prod_reg >>> 16);
                mul_a      = $signed({2'b0, gain.k2});
                mul_b      = 33'(v_reg);
                prod_next  = mul_a * mul_b;
                state_next = lrf_pkg::LANE_DEMAND;
            end
            lrf_pkg::LANE_DEMAND:
            begin
                d_next     = t1_reg - DW'(prod_reg >>> 16);
                x_next     = $signed({1'b0, lim.jerk});
                sel_next   = lrf_pkg::DIV_JERK;
                state_next = lrf_pkg::LANE_DIV_LO;
            end
            lrf_pkg::LANE_DIV_LO:
            begin
                prod_next  = mul_a * mul_b;
                state_next = lrf_pkg::LANE_DIV_HI;
            end
            lrf_pkg::LANE_DIV_HI:
            begin
                lo_next    = prod_reg;
                mul_b      = $signed({9'b0, RECIP_HI});
                prod_next  = mul_a * mul_b;
                state_next = lrf_pkg::LANE_DIV_Q;
            end
            lrf_pkg::LANE_DIV_Q:
            begin
                // estimate is the floor quotient or one below it
                q0_next    = 33'(qsum >>> 48);
                state_next = lrf_pkg::LANE_DIV_FIX;
            end
            lrf_pkg::LANE_DIV_FIX:
            begin
                q_next     = (rem >= $signed(49'(TICK_C))) ? q0_reg + 33'sd1 : q0_reg;
                state_next = lrf_pkg::LANE_APPLY;
            end
            lrf_pkg::LANE_APPLY:
            begin
                unique case (sel_reg)
                    lrf_pkg::DIV_JERK:
                    begin
                        na_next    = sat_word(na_w);
                        x_next     = sat_word(na_w);
                        sel_next   = lrf_pkg::DIV_ACC;
                        state_next = lrf_pkg::LANE_DIV_LO;
                    end
                    lrf_pkg::DIV_ACC:
                    begin
                        nv_next    = sat_word(nv_w);
                        x_next     = sat_word(nv_w);
                        sel_next   = lrf_pkg::DIV_VEL;
                        state_next = lrf_pkg::LANE_DIV_LO;
                    end
                    lrf_pkg::DIV_VEL:
                    begin
                        p_next     = sat_word(DW'(p_reg) + DW'(q_reg));
                        v_next     = nv_reg;
                        a_next     = na_reg;
                        state_next = lrf_pkg::LANE_IDLE;
                    end
                    default:
                    begin
                        state_next = lrf_pkg::LANE_IDLE;
                    end
                endcase
            end
            default:
            begin
                state_next = lrf_pkg::LANE_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != lrf_pkg::LANE_IDLE);
    assign pos  = p_reg;
    assign vel  = v_reg;
    assign acc  = a_reg;

    a_restart_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lrf_pkg::LANE_IDLE && start && restart
        |=> state_reg == lrf_pkg::LANE_IDLE && v_reg == '0 && a_reg == '0)
        else $error("restart did not clear rates");

    a_state_only_at_commit: assert property (@(posedge clk) disable iff (!rst_n)
        busy && !(state_reg == lrf_pkg::LANE_APPLY && sel_reg == lrf_pkg::DIV_VEL)
        |=> $stable(p_reg) && $stable(v_reg) && $stable(a_reg))
        else $error("lane state changed mid sequence");

    a_fix_leads_apply: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lrf_pkg::LANE_DIV_FIX |=> state_reg == lrf_pkg::LANE_APPLY)
        else $error("divider sequence broken");

endmodule

// ----- rtl/limited_reference_filter.sv -----
// ----------------------------------------------------------------------------
// limited_reference_filter
// Jerk-limited second-order reference filter for x, y, z and heading.
// ----------------------------------------------------------------------------
// Usage: each request on the tick channel (tick_valid/tick_ready, payload
// tick) carries the commanded pose, the measured pose and a restart flag.
// Exactly one result per request leaves on the result channel
// (result_valid/result_ready, payload result): the reference position,
// velocity and acceleration of each axis and of heading after the tick.
// A restart request loads the reference from the measurement and zeroes
// rates. A normal request first forms the gains, then four lanes run in
// parallel through 19 steps, each on its own multiplier and divide-by-tick
// unit. A new request is taken only once the previous one has moved into
// the output register, so the block works on one request at a time.
// If the receiver stalls, the result waits in the output register and the
// next request is taken and computed; its result then waits until the
// output register frees up. Reset zeroes the reference and loads the default
// natural frequency, damping ratio and limits into the APB registers.
// ----------------------------------------------------------------------------
module limited_reference_filter #(
    parameter int TICK_HZ   = 100,
    parameter int WORD_BITS = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             tick_valid,
    output logic             tick_ready,
    input  lrf_pkg::tick_t   tick,
    output logic             result_valid,
    input  logic             result_ready,
    output lrf_pkg::result_t result,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [4:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int LANES = 4;

    lrf_pkg::top_state_t state_reg, state_next;
    lrf_pkg::tick_t      tick_reg, tick_next;
    lrf_pkg::result_t    result_reg, result_next;
    logic                result_valid_reg, result_valid_next;

    logic [30:0] cfg_reg [8];
    lrf_pkg::reg_idx_t reg_idx;
    logic        wr_en;

    logic           gain_start, gain_done;
    lrf_pkg::gain_t gain;
    logic           lane_start, lane_restart;
    logic [LANES-1:0] lane_busy;
    logic signed [31:0] lane_cmd  [LANES];
    logic signed [31:0] lane_meas [LANES];
    logic signed [31:0] lane_pos  [LANES];
    logic signed [31:0] lane_vel  [LANES];
    logic signed [31:0] lane_acc  [LANES];
    lrf_pkg::limits_t   lane_lim  [LANES];

    // configuration port
    assign pready  = 1'b1;
    assign reg_idx = lrf_pkg::reg_idx_t'(paddr[4:2]);
    assign wr_en   = psel && penable && pwrite;
    assign prdata  = {1'b0, cfg_reg[reg_idx]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[lrf_pkg::REG_NATURAL_FREQ]   <= lrf_pkg::NATURAL_FREQ_RST;
            cfg_reg[lrf_pkg::REG_DAMPING_RATIO]  <= lrf_pkg::DAMPING_RATIO_RST;
            cfg_reg[lrf_pkg::REG_LIN_JERK_LIMIT] <= lrf_pkg::JERK_LIMIT_RST;
            cfg_reg[lrf_pkg::REG_LIN_ACC_LIMIT]  <= lrf_pkg::ACC_LIMIT_RST;
            cfg_reg[lrf_pkg::REG_LIN_VEL_LIMIT]  <= lrf_pkg::VEL_LIMIT_RST;
            cfg_reg[lrf_pkg::REG_YAW_JERK_LIMIT] <= lrf_pkg::JERK_LIMIT_RST;
            cfg_reg[lrf_pkg::REG_YAW_ACC_LIMIT]  <= lrf_pkg::ACC_LIMIT_RST;
            cfg_reg[lrf_pkg::REG_YAW_VEL_LIMIT]  <= lrf_pkg::VEL_LIMIT_RST;
        end
        else if (wr_en)
        begin
            cfg_reg[reg_idx] <= pwdata[30:0];
        end
    end

    // sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= lrf_pkg::TOP_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tick_reg   <= tick_next;
        result_reg <= result_next;
    end

    always_comb
    begin
        state_next        = state_reg;
        tick_next         = tick_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && !result_ready;
        gain_start        = 1'b0;
        lane_start        = 1'b0;
        lane_restart      = tick_reg.restart;
        unique case (state_reg)
            lrf_pkg::TOP_IDLE:
            begin
                if (tick_valid)
                begin
                    tick_next = tick;
                    if (tick.restart)
                    begin
                        state_next = lrf_pkg::TOP_RUN;
                    end
                    else
                    begin
                        gain_start = 1'b1;
                        state_next = lrf_pkg::TOP_GAIN;
                    end
                end
            end
            lrf_pkg::TOP_GAIN:
            begin
                if (gain_done)
                begin
                    lane_start = 1'b1;
                    state_next = lrf_pkg::TOP_RUN;
                end
            end
            lrf_pkg::TOP_RUN:
            begin
                // a restart request loads the lanes here
                lane_start = tick_reg.restart;
                if (tick_reg.restart || lane_busy == '0)
                begin
                    state_next = lrf_pkg::TOP_DONE;
                end
            end
            lrf_pkg::TOP_DONE:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    // merge lane states into one result
                    result_next.pos_x         = lane_pos[0];
                    result_next.pos_y         = lane_pos[1];
                    result_next.pos_z         = lane_pos[2];
                    result_next.vel_x         = lane_vel[0];
                    result_next.vel_y         = lane_vel[1];
                    result_next.vel_z         = lane_vel[2];
                    result_next.acc_x         = lane_acc[0];
                    result_next.acc_y         = lane_acc[1];
                    result_next.acc_z         = lane_acc[2];
                    result_next.heading       = lane_pos[3];
                    result_next.heading_rate  = lane_vel[3];
                    result_next.heading_accel = lane_acc[3];
                    result_valid_next         = 1'b1;
                    state_next                = lrf_pkg::TOP_IDLE;
                end
            end
            default:
            begin
                state_next = lrf_pkg::TOP_IDLE;
            end
        endcase
    end

    assign tick_ready   = (state_reg == lrf_pkg::TOP_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    lrf_gain u_gain (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (gain_start),
        .natural_freq  (cfg_reg[lrf_pkg::REG_NATURAL_FREQ]),
        .damping_ratio (cfg_reg[lrf_pkg::REG_DAMPING_RATIO]),
        .done          (gain_done),
        .gain          (gain)
    );

    assign lane_cmd[0]  = tick_reg.cmd_x;
    assign lane_cmd[1]  = tick_reg.cmd_y;
    assign lane_cmd[2]  = tick_reg.cmd_z;
    assign lane_cmd[3]  = tick_reg.cmd_heading;
    assign lane_meas[0] = tick_reg.meas_x;
    assign lane_meas[1] = tick_reg.meas_y;
    assign lane_meas[2] = tick_reg.meas_z;
    assign lane_meas[3] = tick_reg.meas_heading;

    assign lane_lim[0] = '{jerk: cfg_reg[lrf_pkg::REG_LIN_JERK_LIMIT],
                           acc:  cfg_reg[lrf_pkg::REG_LIN_ACC_LIMIT],
                           vel:  cfg_reg[lrf_pkg::REG_LIN_VEL_LIMIT]};
    assign lane_lim[1] = lane_lim[0];
    assign lane_lim[2] = lane_lim[0];
    assign lane_lim[3] = '{jerk: cfg_reg[lrf_pkg::REG_YAW_JERK_LIMIT],
                           acc:  cfg_reg[lrf_pkg::REG_YAW_ACC_LIMIT],
                           vel:  cfg_reg[lrf_pkg::REG_YAW_VEL_LIMIT]};

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        lrf_lane #(
            .TICK_HZ   (TICK_HZ),
            .WORD_BITS (WORD_BITS),
            .ANGLE     (g == LANES - 1)
        ) u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .start   (lane_start),
            .restart (lane_restart),
            .cmd     (lane_cmd[g]),
            .meas    (lane_meas[g]),
            .gain    (gain),
            .lim     (lane_lim[g]),
            .busy    (lane_busy[g]),
            .pos     (lane_pos[g]),
            .vel     (lane_vel[g]),
            .acc     (lane_acc[g])
        );
    end

    a_one_request_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        tick_valid && tick_ready |=> !tick_ready)
        else $error("request taken while busy");

    a_lanes_only_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        lane_busy != '0 |-> state_reg == lrf_pkg::TOP_RUN)
        else $error("lane busy outside run");

    a_lanes_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        lane_busy == '0 || lane_busy == '1)
        else $error("lanes out of step");

    a_done_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lrf_pkg::TOP_DONE && (!result_valid_reg || result_ready)
        |=> result_valid_reg)
        else $error("result not loaded");

endmodule
